>>> src/assert_macros.svh
// Assertion macros used by the checker of the dither block.
// Each macro expands to one labeled concurrent assertion that reports through $error.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define RFSD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property that must hold at every clock edge seen while reset is asserted.
`define RFSD_ASSERT_IN_RESET(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) !rst_n |-> prop) \
    else $error(msg);

`endif

>>> src/rfsd_pkg.sv
// Package of the RGB Floyd-Steinberg dither block: port widths, register indexes, constants.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package rfsd_pkg;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    // Configuration port.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 11'd64;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd64;

    // Luma weights, sum taken >> 8.
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd151;
    localparam logic [7:0] LUMA_B = 8'd28;

    // Error diffusion weights in sixteenths.
    localparam logic [2:0] WT_RIGHT      = 3'd7;
    localparam logic [2:0] WT_DOWN_LEFT  = 3'd3;
    localparam logic [2:0] WT_DOWN       = 3'd5;
    localparam logic [2:0] WT_DOWN_RIGHT = 3'd1;

    localparam logic [7:0] PIXEL_MAX = 8'd255;

endpackage

`default_nettype wire

>>> src/rfsd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module rfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/rgb_floyd_steinberg_dither_top.sv
// Top level of the RGB Floyd-Steinberg black/white dither block.
// Depends on rfsd_pkg and on rfsd_ram, which holds the pending errors for the next row.
//
// Usage:
// The block takes RGB888 pixels in raster order on the s_axis channel and returns one
// dithered black or white pixel per input beat on the m_axis channel, in the same order.
// Luma is (77r + 151g + 28b) >> 8; the error diffused to the position is added, the sum
// is saturated to 0..255 and thresholded at 128. The error is spread 7/16 right,
// 3/16 down-left, 5/16 down and 1/16 down-right, never past the image edges.
// The cfg channel writes image_width (index 0) and image_height (index 1); it is always
// ready and must only be used while no pixel is in flight. A width or height of zero is
// taken as one, a value above the maximum as that maximum.
// m_axis_tlast marks the final pixel of each image; the column and row counters wrap
// there, so the next beat starts a new image.
// An accepted beat is held in the second stage, then its result in the output register.
// Throughput is one pixel per cycle while the receiver keeps up: the right-neighbor error
// is a same-cycle add in the second stage, and the line store is read in the first stage
// and written back in the second, with a one-entry write buffer for the extra write at the
// end of each row and forwarding where a read meets a recent write to the same entry.
// When the receiver stalls, the result waits in the output register and one more pixel
// can sit in the second stage; s_axis_tready drops only when both are full.
// Reset clears the counters, the carried errors and all valid flags and restores both
// dimensions to 64. The line store needs no clearing: row 0 never uses what it reads.
`default_nettype none

module rgb_floyd_steinberg_dither_top
    import rfsd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    // Pixel input stream.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    // Dithered output stream.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // pixel_white [0], zero [7:1]
    output logic                        m_axis_tlast    // last_of_image
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (DW > CFG_W) ? DW : CFG_W;
    localparam int HCW = (HW > CFG_W) ? HW : CFG_W;

    // Everything the second stage needs to know about a pixel.
    typedef struct packed {
        logic [XW-1:0] x;
        logic          first_row;
        logic          first_col;
        logic          last_col;
        logic          last_row;
        logic [7:0]    luma;
    } stage_t;

    // e * w / 16, truncated toward zero.
    function automatic logic signed [7:0] share(input logic signed [7:0] e,
                                                input logic [2:0] w);
        logic [7:0] neg;
        logic [6:0] mag;
        logic [9:0] prod;
        logic [7:0] q;
        neg  = 8'(-e);
        mag  = e[7] ? neg[6:0] : e[6:0];
        prod = 10'(mag) * 10'(w);
        q    = {2'b00, prod[9:4]};
        return e[7] ? 8'(-q) : q;
    endfunction

    // Configuration and counters.
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [WCW-1:0]   width_eff;
    logic [HCW-1:0]   height_eff;
    logic [XW-1:0]    x_cnt_reg;
    logic [XW-1:0]    x_cnt_next;
    logic [YW-1:0]    y_cnt_reg;
    logic [YW-1:0]    y_cnt_next;

    // Pipeline.
    logic             in_accept;
    logic             s1_adv;
    logic             s1_valid_reg;
    stage_t           s1_reg;
    stage_t           s1_next;
    logic [15:0]      luma_full;
    logic             out_valid_reg;
    logic             out_white_reg;
    logic             out_last_reg;

    // Carried errors.
    logic signed [7:0] rc_reg;
    logic signed [7:0] bw0_reg;
    logic signed [7:0] bw1_reg;

    // Line store access.
    logic             ram_we;
    logic [XW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;
    logic             pend_valid_reg;
    logic [XW-1:0]    pend_addr_reg;
    logic [7:0]       pend_data_reg;
    logic             pend_hit;
    logic             ovr_valid_reg;
    logic [7:0]       ovr_data_reg;

    // Second-stage arithmetic.
    logic signed [7:0]  ls_eff;
    logic signed [7:0]  ls_term;
    logic signed [10:0] sum;
    logic [7:0]         sat;
    logic               white;
    logic signed [8:0]  err9;
    logic signed [7:0]  err;
    logic signed [7:0]  sh_right;
    logic signed [7:0]  sh_down_left;
    logic signed [7:0]  sh_down;
    logic signed [7:0]  sh_down_right;
    logic signed [7:0]  bw0_new;
    logic signed [7:0]  bw1_new;
    logic               dir_we;
    logic [7:0]         dir_data;

    assign cfg_ready = 1'b1;

    // Dimensions as used: zero counts as one, oversize counts as the maximum.
    always_comb
    begin
        if (width_cfg_reg == '0)
            width_eff = WCW'(1);
        else if (WCW'(width_cfg_reg) > WCW'(MAX_WIDTH))
            width_eff = WCW'(MAX_WIDTH);
        else
            width_eff = WCW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            height_eff = HCW'(1);
        else if (HCW'(height_cfg_reg) > HCW'(MAX_HEIGHT))
            height_eff = HCW'(MAX_HEIGHT);
        else
            height_eff = HCW'(height_cfg_reg);
    end

    // Handshakes: the second stage moves on whenever the output register is free.
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // First stage: luma and position flags of the incoming beat.
    assign luma_full = 16'(s_axis_tdata[7:0])   * 16'(LUMA_R)
                     + 16'(s_axis_tdata[15:8])  * 16'(LUMA_G)
                     + 16'(s_axis_tdata[23:16]) * 16'(LUMA_B);

    always_comb
    begin
        s1_next.x         = x_cnt_reg;
        s1_next.first_row = (y_cnt_reg == '0);
        s1_next.first_col = (x_cnt_reg == '0);
        s1_next.last_col  = ((WCW'(x_cnt_reg) + WCW'(1)) >= width_eff);
        s1_next.last_row  = ((HCW'(y_cnt_reg) + HCW'(1)) >= height_eff);
        s1_next.luma      = luma_full[15:8];

        if (s1_next.last_col)
        begin
            x_cnt_next = '0;
            y_cnt_next = s1_next.last_row ? '0 : YW'(y_cnt_reg + 1'b1);
        end
        else
        begin
            x_cnt_next = XW'(x_cnt_reg + 1'b1);
            y_cnt_next = y_cnt_reg;
        end
    end

    // Second stage: pending error for this column, with forwarding from the write buffer
    // and from any write that hit the entry after its read was issued.
    assign pend_hit = pend_valid_reg && (pend_addr_reg == s1_reg.x);

    always_comb
    begin
        if (pend_hit)
            ls_eff = pend_data_reg;
        else if (ovr_valid_reg)
            ls_eff = ovr_data_reg;
        else
            ls_eff = ram_rdata;

        ls_term = s1_reg.first_row ? 8'sd0 : ls_eff;
        sum     = $signed({3'b000, s1_reg.luma}) + 11'(rc_reg) + 11'(ls_term);

        if (sum < 0)
            sat = 8'd0;
        else if (sum > 11'sd255)
            sat = PIXEL_MAX;
        else
            sat = sum[7:0];

        white = sat[7];
        err9  = $signed({1'b0, sat}) - (white ? $signed({1'b0, PIXEL_MAX}) : 9'sd0);
        err   = err9[7:0];

        sh_right      = share(err, WT_RIGHT);
        sh_down_left  = share(err, WT_DOWN_LEFT);
        sh_down       = share(err, WT_DOWN);
        sh_down_right = share(err, WT_DOWN_RIGHT);

        dir_data = 8'(bw0_reg + sh_down_left);
        bw0_new  = 8'(bw1_reg + sh_down);
        bw1_new  = s1_reg.last_col ? 8'sd0 : sh_down_right;
        dir_we   = s1_adv && !s1_reg.last_row && !s1_reg.first_col;
    end

    // The buffered end-of-row write always falls in a cycle where the second stage holds
    // the first pixel of a row or nothing, so it never meets a direct write.
    always_comb
    begin
        ram_we = pend_valid_reg || dir_we;
        if (pend_valid_reg)
        begin
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_data_reg;
        end
        else
        begin
            ram_waddr = XW'(s1_reg.x - 1'b1);
            ram_wdata = dir_data;
        end
    end

    rfsd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (x_cnt_reg),
        .rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= IMAGE_WIDTH_RESET;
            height_cfg_reg <= IMAGE_HEIGHT_RESET;
            x_cnt_reg      <= '0;
            y_cnt_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            rc_reg         <= '0;
            bw0_reg        <= '0;
            bw1_reg        <= '0;
            pend_valid_reg <= 1'b0;
            ovr_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                endcase
            end

            if (in_accept)
            begin
                x_cnt_reg <= x_cnt_next;
                y_cnt_reg <= y_cnt_next;
            end

            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            pend_valid_reg <= s1_adv && s1_reg.last_col && !s1_reg.last_row;

            if (in_accept)
                ovr_valid_reg <= ram_we && (ram_waddr == x_cnt_reg);
            else if (s1_valid_reg && !s1_adv && pend_hit)
                ovr_valid_reg <= 1'b1;

            if (s1_adv)
            begin
                rc_reg <= s1_reg.last_col ? 8'sd0 : sh_right;
                if (s1_reg.last_col)
                begin
                    bw0_reg <= '0;
                    bw1_reg <= '0;
                end
                else if (!s1_reg.last_row)
                begin
                    bw0_reg <= bw0_new;
                    bw1_reg <= bw1_new;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= s1_next;
        end

        if (s1_adv)
        begin
            out_white_reg <= white;
            out_last_reg  <= s1_reg.last_col && s1_reg.last_row;
            pend_addr_reg <= s1_reg.x;
            pend_data_reg <= bw0_new;
        end

        if (in_accept)
            ovr_data_reg <= ram_wdata;
        else if (s1_valid_reg && !s1_adv && pend_hit)
            ovr_data_reg <= pend_data_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - 1)'(0), out_white_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> src/rfsd_checker.sv
// Port-level checker of the RGB Floyd-Steinberg dither block, bound to its top level.
// Depends on rfsd_pkg and on the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rfsd_checker
    import rfsd_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    // A stalled result beat holds its payload.
    `RFSD_ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output beat changed")

    // A receiver that takes beats never blocks the input side.
    `RFSD_ASSERT_CLK(a_ready_when_drained, clk, rst_n, m_axis_tready |-> s_axis_tready, "input stalled while output drains")

    // A result beat appears only after an accepted input beat.
    `RFSD_ASSERT_CLK(a_out_from_in, clk, rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "output beat without matching input beat")

    // No result beat is offered during reset.
    `RFSD_ASSERT_IN_RESET(a_reset_quiet, clk, rst_n, !m_axis_tvalid, "output valid during reset")

endmodule

bind rgb_floyd_steinberg_dither_top rfsd_checker u_rfsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/rgb_floyd_steinberg_dither_top_tb.sv
`timescale 1ns / 100ps
// Testbench of rgb_floyd_steinberg_dither_top: drives RGB888 pixel beats and checks every
// dithered beat against an in-bench error-diffusion predictor. Depends on rfsd_pkg and the RTL.

module rgb_floyd_steinberg_dither_top_tb;

    import rfsd_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int CLK_HALF      = 2;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PIXELS = 450;

    // Pixel content styles for generated images.
    typedef enum int {
        STYLE_UNIFORM,
        STYLE_THRESHOLD,
        STYLE_GRADIENT,
        STYLE_SATURATED
    } pixel_style_t;

    // One dithered pixel as the block should return it.
    typedef struct packed {
        logic white;
        logic last;
    } bw_pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // red [7:0], green [15:8], blue [23:16]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // pixel_white [0], zero [7:1]
    logic                   m_axis_tlast;   // last_of_image

    // Dithered pixels predicted for accepted input beats, oldest first.
    bw_pixel_t dithered_q[$];
    int        mismatches  = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;

    // Predictor state: a private copy of the dimensions, the pending errors and the
    // raster position. Pending errors are signed bytes, as in the block.
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic signed [7:0] err_next_row [MAX_W];
    logic signed [7:0] err_right;
    logic signed [7:0] err_below_here;
    logic signed [7:0] err_below_right;
    int                img_col;
    int                img_row;

    rgb_floyd_steinberg_dither_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // A dimension register of zero behaves as one, anything above the maximum as the maximum.
    function automatic int effective_dim(logic [CFG_W-1:0] raw, int max_dim);
        if (raw == '0)
            return 1;
        if (int'(raw) > max_dim)
            return max_dim;
        return int'(raw);
    endfunction

    // Share of an error in sixteenths, truncated toward zero for both signs.
    function automatic int diffuse_share(int err, int sixteenths);
        int mag;
        mag = (err < 0) ? -err : err;
        mag = (mag * sixteenths) / 16;
        return (err < 0) ? -mag : mag;
    endfunction

    // Dithers one accepted pixel, advances the predictor state and queues the result.
    task automatic dither_pixel(input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue);
        int        w;
        int        h;
        int        x;
        int        y;
        int        xi;
        int        level;
        int        err;
        int        acc;
        int        nxt;
        bit        last_col;
        bit        last_row;
        bw_pixel_t res;
        w        = effective_dim(width_reg, MAX_W);
        h        = effective_dim(height_reg, MAX_H);
        x        = img_col;
        y        = img_row;
        xi       = x % MAX_W;
        last_col = (x + 1 >= w);
        last_row = (y + 1 >= h);

        // Luma, then the error pending from the left and, below row 0, from the row above.
        level = int'((77 * red + 151 * green + 28 * blue) >> 8);
        level = level + err_right;
        if (y != 0)
            level = level + err_next_row[xi];
        if (level < 0)
            level = 0;
        if (level > 255)
            level = 255;
        res.white = (level >= 128);
        err       = level - (res.white ? 255 : 0);

        err_right = last_col ? 8'sd0 : 8'(diffuse_share(err, 7));

        // The two-entry window collects the down and down-right shares; the down-left
        // share completes the entry one column back, which is then final.
        if (!last_row)
        begin
            acc = err_below_here;
            nxt = err_below_right;
            if (x != 0)
            begin
                acc = acc + diffuse_share(err, 3);
                err_next_row[(xi + MAX_W - 1) % MAX_W] = 8'(acc);
            end
            acc             = nxt + diffuse_share(err, 5);
            nxt             = last_col ? 0 : diffuse_share(err, 1);
            err_below_here  = 8'(acc);
            err_below_right = 8'(nxt);
            if (last_col)
                err_next_row[xi] = 8'(acc);
        end
        if (last_col)
        begin
            err_below_here  = '0;
            err_below_right = '0;
        end

        if (last_col)
        begin
            img_col = 0;
            img_row = last_row ? 0 : y + 1;
        end
        else
        begin
            img_col = x + 1;
        end

        res.last = last_col && last_row;
        dithered_q.push_back(res);
    endtask

    // ------------------------------------------------------------------------------------
    // Result checking: every accepted output beat is matched against the oldest prediction.
    // ------------------------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        bw_pixel_t              want;
        logic [OUT_TDATA_W-1:0] want_tdata;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (dithered_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing expected, tdata=%h tlast=%b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want       = dithered_q.pop_front();
                want_tdata = '0;
                want_tdata[0] = want.white;
                if (m_axis_tdata !== want_tdata)
                begin
                    mismatches++;
                    $display("%0t: pixel_white mismatch, expected tdata=%h actual tdata=%h",
                             $time, want_tdata, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last_of_image mismatch, expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // The receiver switches between stall patterns: always ready, coin flips, a regular
    // one-in-four stall and long stalls with rare ready cycles.
    always @(posedge clk)
    begin : drive_result_ready
        int rx_mode;
        int rx_left;
        int rx_phase;
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(32, 256);
        end
        else
        begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (rx_phase % 4 != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: ends a run that hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, dithered_q.size());
        $display("** rgb_floyd_steinberg_dither_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------------------

    // Sends one pixel beat. The sender works in bursts; between bursts tvalid drops for a
    // random gap, sometimes none, so long unbroken stretches occur as well.
    task automatic send_pixel(input logic [IN_TDATA_W-1:0] rgb);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rgb;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        dither_pixel(rgb[7:0], rgb[15:8], rgb[23:16]);
    endtask

    // Stops sending and waits until every predicted pixel has come back, which leaves the
    // block idle: each beat yields exactly one result.
    task automatic drain_pixels();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (dithered_q.size() != 0)
            @(posedge clk);
    endtask

    // Writes both dimension registers back to back; only called while the block is idle.
    task automatic set_image_size(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        cfg_valid <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w_raw;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        width_reg = w_raw;
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h_raw;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        height_reg = h_raw;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [IN_TDATA_W-1:0] pick_pixel(pixel_style_t style, int idx);
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        int         base;
        case (style)
            STYLE_THRESHOLD:
            begin
                // Grays near mid level keep the sum close to the threshold.
                base  = $urandom_range(112, 144);
                red   = 8'(base + int'($urandom_range(0, 8)) - 4);
                green = 8'(base + int'($urandom_range(0, 8)) - 4);
                blue  = 8'(base + int'($urandom_range(0, 8)) - 4);
            end
            STYLE_GRADIENT:
            begin
                red   = 8'(idx * 5);
                green = 8'(idx * 3 + 64);
                blue  = 8'(255 - idx * 2);
            end
            STYLE_SATURATED:
            begin
                red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
            begin
                red   = 8'($urandom);
                green = 8'($urandom);
                blue  = 8'($urandom);
            end
        endcase
        return {blue, green, red};
    endfunction

    function automatic pixel_style_t pick_style();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 8)
            return STYLE_UNIFORM;
        if (roll < 13)
            return STYLE_THRESHOLD;
        if (roll < 16)
            return STYLE_GRADIENT;
        return STYLE_SATURATED;
    endfunction

    // Sends pixels until the predicted raster position wraps to the start of an image.
    task automatic send_image(input pixel_style_t style);
        int idx;
        idx = 0;
        do
        begin
            send_pixel(pick_pixel(style, idx));
            idx++;
        end
        while (img_col != 0 || img_row != 0);
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Black, white, pure primaries and mid gray on a 3x2 image, so the first row, the last
    // row and both edges all see an extreme.
    task automatic test_corner_colors();
        logic [IN_TDATA_W-1:0] corners [6];
        corners = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h808080};
        drain_pixels();
        set_image_size(11'd3, 11'd2);
        foreach (corners[i])
            send_pixel(corners[i]);
    endtask

    // Zero dimensions act as a 1x1 image: every beat is the last of its image.
    task automatic test_size_clamping();
        drain_pixels();
        set_image_size(11'd0, 11'd0);
        send_pixel(24'h7F7F7F);
        send_pixel(24'h808080);
        send_pixel(pick_pixel(STYLE_UNIFORM, 0));
    endtask

    // Shrinking the image mid-way: the column counter, and then the row counter, end up at
    // or past the new last position and must wrap on the next beat. Only shrinking is
    // used, so every line-store entry read was written by the row above.
    task automatic test_size_change_mid_image();
        drain_pixels();
        set_image_size(11'd5, 11'd4);
        repeat (7)
            send_pixel(pick_pixel(STYLE_THRESHOLD, 0));
        drain_pixels();
        set_image_size(11'd3, 11'd3);
        send_image(STYLE_THRESHOLD);

        // A height above the maximum, cut down to three rows while on row five.
        drain_pixels();
        set_image_size(11'd1, 11'd2047);
        repeat (5)
            send_pixel(pick_pixel(STYLE_UNIFORM, 0));
        drain_pixels();
        set_image_size(11'd1, 11'd3);
        send_image(STYLE_UNIFORM);
    endtask

    // A width above the maximum is used as the maximum; one row runs the column counter
    // over its whole range.
    task automatic test_widest_image();
        drain_pixels();
        set_image_size(11'd2047, 11'd1);
        send_image(STYLE_THRESHOLD);
    endtask

    // A single column over many rows: every pixel is both first and last column.
    task automatic test_tallest_image();
        drain_pixels();
        set_image_size(11'd0, 11'd400);
        send_image(STYLE_UNIFORM);
    endtask

    // Mostly small images with random content; some are shrunk part of the way through.
    task automatic test_random_images();
        int               sent;
        int               w;
        int               h;
        int               idx;
        int               cut;
        pixel_style_t     style;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            w     = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            h     = $urandom_range(1, 6);
            w_raw = (w == 1 && $urandom_range(0, 1)) ? '0 : CFG_W'(w);
            h_raw = (h == 1 && $urandom_range(0, 1)) ? '0 : CFG_W'(h);
            style = pick_style();
            cut   = (w * h > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, w * h - 1) : -1;
            drain_pixels();
            set_image_size(w_raw, h_raw);
            idx = 0;
            do
            begin
                if (idx == cut)
                begin
                    drain_pixels();
                    set_image_size(CFG_W'($urandom_range(1, w)), CFG_W'($urandom_range(1, h)));
                end
                send_pixel(pick_pixel(style, idx));
                idx++;
                sent++;
            end
            while (img_col != 0 || img_row != 0);
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b1;
        cfg_valid     = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // Predictor state after reset; the line store starts at zero in the predictor
        // and is never read before being written.
        width_reg       = IMAGE_WIDTH_RESET;
        height_reg      = IMAGE_HEIGHT_RESET;
        err_right       = '0;
        err_below_here  = '0;
        err_below_right = '0;
        img_col         = 0;
        img_row         = 0;
        foreach (err_next_row[i])
            err_next_row[i] = '0;

        // Reset falls shortly after time zero, so the asynchronous reset sees a clean
        // falling edge before the first rising clock edge.
        #1;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_colors();
        test_size_clamping();
        test_size_change_mid_image();
        test_widest_image();
        test_tallest_image();
        test_random_images();

        drain_pixels();
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("** rgb_floyd_steinberg_dither_top: PASSED **");
        else
            $display("** rgb_floyd_steinberg_dither_top: FAILED **");
        $finish;
    end

endmodule
